// ===== sv/hit_charge_classify_undeflect_unit_assert.svh =====
// ----------------------------------------------------------------------------
// hit charge classify assertion macros
// shared property shapes for the charge classifier checks, clocked on clk
// and held off during rst
// ----------------------------------------------------------------------------
`ifndef HIT_CHARGE_CLASSIFY_UNDEFLECT_UNIT_ASSERT_SVH
`define HIT_CHARGE_CLASSIFY_UNDEFLECT_UNIT_ASSERT_SVH

// same-cycle implication
`define HCCU_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HCCU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/hccu_pkg.sv =====
// ----------------------------------------------------------------------------
// hccu_pkg
// shared constants and types of the hit charge classifier
// ----------------------------------------------------------------------------
package hccu_pkg;

  localparam int NUM_CIRCLES  = 5;
  localparam int CHARGE_W     = 3;
  localparam int APB_ADDR_W   = 6;
  localparam int APB_DATA_W   = 64;
  localparam int OUT_TDATA_W  = 96;
  localparam int OUT_TUSER_W  = 4;

  // register index, taken from paddr[5:3]
  typedef enum logic [2:0] {
    REG_CIRCLE_ZERO  = 3'd0,
    REG_CIRCLE_ONE   = 3'd1,
    REG_CIRCLE_TWO   = 3'd2,
    REG_CIRCLE_THREE = 3'd3,
    REG_CIRCLE_FOUR  = 3'd4
  } hccu_reg_t;

  // load enables of the three lane stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } hccu_stage_en_t;

endpackage

// ===== sv/hccu_circle_lane.sv =====
// ----------------------------------------------------------------------------
// hccu_circle_lane
// three-stage containment test of one hit against one circle
// ----------------------------------------------------------------------------
module hccu_circle_lane
  import hccu_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                      clk,
  input  hccu_stage_en_t            en,
  input  logic [COORD_BITS-1:0]     hit_x,
  input  logic [COORD_BITS-1:0]     hit_y,
  input  logic [3*COORD_BITS-1:0]   circle,
  output logic                      in_circle
);

  localparam int CB = COORD_BITS;

  logic [CB-1:0]        cen_x;
  logic [CB-1:0]        cen_y;
  logic [CB-1:0]        rad;

  // stage 1: offsets
  logic signed [CB:0]   dx;
  logic signed [CB:0]   dy;
  logic [CB-1:0]        r1;

  // stage 2: squares
  logic signed [2*CB+1:0] dx_sq_full;
  logic signed [2*CB+1:0] dy_sq_full;
  logic [2*CB-1:0]      dx_sq;
  logic [2*CB-1:0]      dy_sq;
  logic [2*CB-1:0]      r_sq;

  assign cen_x = circle[3*CB-1:2*CB];
  assign cen_y = circle[2*CB-1:CB];
  assign rad   = circle[CB-1:0];

  assign dx_sq_full = dx * dx;
  assign dy_sq_full = dy * dy;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      dx <= $signed({1'b0, hit_x}) - $signed({1'b0, cen_x});
      dy <= $signed({1'b0, hit_y}) - $signed({1'b0, cen_y});
      r1 <= rad;
    end
    if (en.s2) begin
      // squares are below 2**(2*CB), the top bits are zero
      dx_sq <= dx_sq_full[2*CB-1:0];
      dy_sq <= dy_sq_full[2*CB-1:0];
      r_sq  <= r1 * r1;
    end
    if (en.s3) begin
      in_circle <= ({1'b0, dx_sq} + {1'b0, dy_sq}) <= {1'b0, r_sq};
    end
  end

endmodule

// ===== sv/hit_charge_classify_undeflect_unit.sv =====
// ----------------------------------------------------------------------------
// hit_charge_classify_undeflect_unit
// classifies detector hits by charge and removes the field deflection
// ----------------------------------------------------------------------------
// Each hit request (trigger number, x, y, brightness) is checked against five
// circles, one per charge state 0 to 4; the lowest-charge circle that holds
// the hit, by (x-cx)^2 + (y-cy)^2 <= r^2, sets charge q and matched. A matched
// hit is moved back by q times the center offset between circle one and
// circle two (x - q*(cx2-cx1), y likewise), saturated to 16 bits signed;
// an unmatched hit keeps its position with charge 0. The block takes one
// request every cycle while the result side does not stall, and registers its
// result in four register stages: three stages of offset, square and compare
// run in five parallel circle lanes, and the output register holds the
// priority pick and correction.
// Back-pressure on the result side stalls only the stages that are full, so
// bubbles are squeezed out. Circles are written over the APB port at byte
// address 8*i (i = 0..4), x in the top field, then y, then radius, each
// COORD_BITS wide; paddr[2:0] is not decoded, and register indices 5 to 7
// ignore writes and read zero. Write circles only while no hit is in flight.
// ----------------------------------------------------------------------------
module hit_charge_classify_undeflect_unit
  import hccu_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                      clk,
  input  logic                      rst,

  // hit input
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // trigger_number[31:0], hit_x, hit_y, brightness[31:0], zero pad to bytes
  input  logic [((64+2*COORD_BITS+7)/8)*8-1:0] s_tdata,

  // classified output
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // out_trigger[31:0], corrected_x[15:0], corrected_y[15:0],
  // out_brightness[31:0]
  output logic [OUT_TDATA_W-1:0]    m_tdata,
  // charge[2:0], matched
  output logic [OUT_TUSER_W-1:0]    m_tuser,

  // circle configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_W-1:0]     paddr,
  input  logic [APB_DATA_W-1:0]     pwdata,
  output logic [APB_DATA_W-1:0]     prdata,
  output logic                      pready
);

  localparam int CB      = COORD_BITS;
  localparam int REG_W   = 3*CB;
  // wide enough for x - 4*deflection and for the saturation bounds
  localparam int WW      = (CB + 6 > 17) ? CB + 6 : 17;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [REG_W-1:0]   circle [NUM_CIRCLES];
  hccu_reg_t          reg_sel;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = hccu_reg_t'(paddr[5:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_CIRCLES; k++) begin
        circle[k] <= '0;
      end
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_CIRCLE_ZERO:  circle[0] <= pwdata[REG_W-1:0];
        REG_CIRCLE_ONE:   circle[1] <= pwdata[REG_W-1:0];
        REG_CIRCLE_TWO:   circle[2] <= pwdata[REG_W-1:0];
        REG_CIRCLE_THREE: circle[3] <= pwdata[REG_W-1:0];
        REG_CIRCLE_FOUR:  circle[4] <= pwdata[REG_W-1:0];
        default: ;  // index beyond the circle list, write dropped
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_CIRCLE_ZERO:  prdata = APB_DATA_W'(circle[0]);
      REG_CIRCLE_ONE:   prdata = APB_DATA_W'(circle[1]);
      REG_CIRCLE_TWO:   prdata = APB_DATA_W'(circle[2]);
      REG_CIRCLE_THREE: prdata = APB_DATA_W'(circle[3]);
      REG_CIRCLE_FOUR:  prdata = APB_DATA_W'(circle[4]);
      default:          prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // pipeline control: a stage loads when it is empty or its successor loads
  // --------------------------------------------------------------------------
  logic            v1;
  logic            v2;
  logic            v3;
  logic            vo;
  logic            en_o;
  hccu_stage_en_t  stage_en;

  always_comb begin
    en_o        = !vo || m_tready;
    stage_en.s3 = !v3 || en_o;
    stage_en.s2 = !v2 || stage_en.s3;
    stage_en.s1 = !v1 || stage_en.s2;
  end

  assign s_tready = stage_en.s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (stage_en.s1) v1 <= s_tvalid;
      if (stage_en.s2) v2 <= v1;
      if (stage_en.s3) v3 <= v2;
      if (en_o)        vo <= v3;
    end
  end

  // --------------------------------------------------------------------------
  // input unpack and pass-through payload
  // --------------------------------------------------------------------------
  logic [31:0]    in_trigger;
  logic [CB-1:0]  in_x;
  logic [CB-1:0]  in_y;
  logic [31:0]    in_brightness;

  assign in_trigger    = s_tdata[31:0];
  assign in_x          = s_tdata[32 +: CB];
  assign in_y          = s_tdata[32+CB +: CB];
  assign in_brightness = s_tdata[32+2*CB +: 32];

  logic [31:0]    s1_trigger, s2_trigger, s3_trigger;
  logic [31:0]    s1_bright,  s2_bright,  s3_bright;
  logic [CB-1:0]  s1_x, s2_x, s3_x;
  logic [CB-1:0]  s1_y, s2_y, s3_y;

  always_ff @(posedge clk) begin
    if (stage_en.s1) begin
      s1_trigger <= in_trigger;
      s1_bright  <= in_brightness;
      s1_x       <= in_x;
      s1_y       <= in_y;
    end
    if (stage_en.s2) begin
      s2_trigger <= s1_trigger;
      s2_bright  <= s1_bright;
      s2_x       <= s1_x;
      s2_y       <= s1_y;
    end
    if (stage_en.s3) begin
      s3_trigger <= s2_trigger;
      s3_bright  <= s2_bright;
      s3_x       <= s2_x;
      s3_y       <= s2_y;
    end
  end

  // --------------------------------------------------------------------------
  // circle lanes, one per charge state
  // --------------------------------------------------------------------------
  logic [NUM_CIRCLES-1:0] lane_hit;

  for (genvar k = 0; k < NUM_CIRCLES; k++) begin : g_lane
    hccu_circle_lane #(
      .COORD_BITS (COORD_BITS)
    ) u_lane (
      .clk       (clk),
      .en        (stage_en),
      .hit_x     (in_x),
      .hit_y     (in_y),
      .circle    (circle[k]),
      .in_circle (lane_hit[k])
    );
  end

  // --------------------------------------------------------------------------
  // priority pick and deflection removal, into the output register
  // --------------------------------------------------------------------------
  logic [CHARGE_W-1:0]  charge_sel;
  logic                 any_hit;
  logic signed [CB:0]   def_x;
  logic signed [CB:0]   def_y;
  logic signed [CB+4:0] prod_x;
  logic signed [CB+4:0] prod_y;
  logic signed [WW-1:0] cx_wide;
  logic signed [WW-1:0] cy_wide;
  logic [15:0]          cx_sat;
  logic [15:0]          cy_sat;

  // lowest charge wins; no hit leaves charge 0 and the position untouched
  always_comb begin
    charge_sel = '0;
    for (int k = NUM_CIRCLES - 1; k >= 0; k--) begin
      if (lane_hit[k]) charge_sel = CHARGE_W'(k);
    end
  end

  assign any_hit = |lane_hit;

  // center offset between charge one and charge two spots
  assign def_x = $signed({1'b0, circle[2][3*CB-1:2*CB]})
               - $signed({1'b0, circle[1][3*CB-1:2*CB]});
  assign def_y = $signed({1'b0, circle[2][2*CB-1:CB]})
               - $signed({1'b0, circle[1][2*CB-1:CB]});

  assign prod_x = $signed({1'b0, charge_sel}) * def_x;
  assign prod_y = $signed({1'b0, charge_sel}) * def_y;

  assign cx_wide = WW'($signed({1'b0, s3_x})) - WW'(prod_x);
  assign cy_wide = WW'($signed({1'b0, s3_y})) - WW'(prod_y);

  always_comb begin
    if (cx_wide > $signed(WW'(32767))) begin
      cx_sat = 16'h7fff;
    end else if (cx_wide < -$signed(WW'(32768))) begin
      cx_sat = 16'h8000;
    end else begin
      cx_sat = cx_wide[15:0];
    end
    if (cy_wide > $signed(WW'(32767))) begin
      cy_sat = 16'h7fff;
    end else if (cy_wide < -$signed(WW'(32768))) begin
      cy_sat = 16'h8000;
    end else begin
      cy_sat = cy_wide[15:0];
    end
  end

  logic [31:0]          o_trigger;
  logic [31:0]          o_bright;
  logic [15:0]          o_cx;
  logic [15:0]          o_cy;
  logic [CHARGE_W-1:0]  o_charge;
  logic                 o_matched;

  always_ff @(posedge clk) begin
    if (en_o) begin
      o_trigger <= s3_trigger;
      o_bright  <= s3_bright;
      o_cx      <= cx_sat;
      o_cy      <= cy_sat;
      o_charge  <= charge_sel;
      o_matched <= any_hit;
    end
  end

  assign m_tvalid = vo;
  assign m_tdata  = {o_bright, o_cy, o_cx, o_trigger};
  assign m_tuser  = {o_matched, o_charge};

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
`include "hit_charge_classify_undeflect_unit_assert.svh"

  `HCCU_ASSERT_IMPLY(a_unmatched_zero_charge, vo && !o_matched, o_charge == '0, "unmatched hit carries a charge")
  `HCCU_ASSERT_IMPLY(a_charge_range, vo, o_charge <= CHARGE_W'(NUM_CIRCLES - 1), "charge beyond four")
  `HCCU_ASSERT_NEXT(a_accept_fills, s_tvalid && s_tready, v1, "accepted hit did not enter stage one")
  `HCCU_ASSERT_IMPLY(a_stall_only_full, !s_tready, v1 && v2 && v3 && vo && !m_tready, "input stalled with a free stage")

endmodule

// ===== verif/hccu_classify_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hccu_classify_checker
// watches the hit, result and circle ports of the charge classifier, works
// out the classified hit for every accepted request and compares results
// in order
// ----------------------------------------------------------------------------
module hccu_classify_checker
  import hccu_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int IN_W       = ((64 + 2*COORD_BITS + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_W-1:0]        s_tdata,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic [OUT_TUSER_W-1:0] m_tuser,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic                   pready,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output int                     failures,
  output int                     pending,
  output int                     matched_seen
);

  typedef struct packed {
    logic [31:0] trig;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [31:0] bright;
    logic [2:0]  charge;
    logic        matched;
  } classified_hit_t;

  logic [3*COORD_BITS-1:0] circles [NUM_CIRCLES];
  classified_hit_t         hit_queue [$];
  int                      fail_cnt;
  int                      match_cnt;

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic classified_hit_t classify_hit(logic [IN_W-1:0] req);
    classified_hit_t res;
    longint x, y, dx, dy, rad, defx, defy, q, ox, oy;
    bit found;
    x = longint'(req[32 +: COORD_BITS]);
    y = longint'(req[32+COORD_BITS +: COORD_BITS]);
    found = 1'b0;
    q = 0;
    // lowest charge wins where circles overlap
    for (int k = 0; k < NUM_CIRCLES; k++) begin
      if (!found) begin
        dx  = x - longint'(circles[k][2*COORD_BITS +: COORD_BITS]);
        dy  = y - longint'(circles[k][COORD_BITS +: COORD_BITS]);
        rad = longint'(circles[k][0 +: COORD_BITS]);
        if (dx*dx + dy*dy <= rad*rad) begin
          found = 1'b1;
          q = k;
        end
      end
    end
    defx = longint'(circles[REG_CIRCLE_TWO][2*COORD_BITS +: COORD_BITS])
         - longint'(circles[REG_CIRCLE_ONE][2*COORD_BITS +: COORD_BITS]);
    defy = longint'(circles[REG_CIRCLE_TWO][COORD_BITS +: COORD_BITS])
         - longint'(circles[REG_CIRCLE_ONE][COORD_BITS +: COORD_BITS]);
    ox = found ? x - q*defx : x;
    oy = found ? y - q*defy : y;
    res.trig    = req[31:0];
    res.cx      = 16'(clip16(ox));
    res.cy      = 16'(clip16(oy));
    res.bright  = req[32+2*COORD_BITS +: 32];
    res.charge  = 3'(q);
    res.matched = found;
    return res;
  endfunction

  task automatic check_field(string what, longint want, longint got);
    if (want != got) begin
      fail_cnt++;
      if (fail_cnt <= 40)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    classified_hit_t want, got;
    if (rst) begin
      for (int k = 0; k < NUM_CIRCLES; k++)
        circles[k] = '0;
      hit_queue.delete();
      fail_cnt  = 0;
      match_cnt = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[APB_ADDR_W-1:3] < NUM_CIRCLES)
        circles[paddr[APB_ADDR_W-1:3]] = pwdata[3*COORD_BITS-1:0];
      if (s_tvalid && s_tready)
        hit_queue.insert(hit_queue.size(), classify_hit(s_tdata));
      if (m_tvalid && m_tready) begin
        got.trig    = m_tdata[31:0];
        got.cx      = m_tdata[47:32];
        got.cy      = m_tdata[63:48];
        got.bright  = m_tdata[95:64];
        got.charge  = m_tuser[2:0];
        got.matched = m_tuser[3];
        if (got.matched)
          match_cnt++;
        if (hit_queue.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 40)
            $display("%0t: result with none expected, expected nothing actual %h %h",
                     $time, m_tdata, m_tuser);
        end else begin
          want = hit_queue.pop_front();
          check_field("out_trigger", want.trig, got.trig);
          check_field("corrected_x", $signed(want.cx), $signed(got.cx));
          check_field("corrected_y", $signed(want.cy), $signed(got.cy));
          check_field("out_brightness", want.bright, got.bright);
          check_field("charge", want.charge, got.charge);
          check_field("matched", want.matched, got.matched);
        end
      end
    end
    failures     <= fail_cnt;
    pending      <= hit_queue.size();
    matched_seen <= match_cnt;
  end

endmodule

// ===== verif/hit_charge_classify_undeflect_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hit_charge_classify_undeflect_unit_test
// drives detector hits and circle settings into the charge classifier with
// random idling on both streams; the checker predicts and compares, and this
// module gives the verdict
// ----------------------------------------------------------------------------
module hit_charge_classify_undeflect_unit_test;
  import hccu_pkg::*;

  localparam int CB             = 12;
  localparam int IN_W           = ((64 + 2*CB + 7) / 8) * 8;
  localparam int CMAX           = (1 << CB) - 1;
  localparam int QUIET_LIMIT    = 2000;  // cycles with no handshake at all
  localparam int RAND_PHASES    = 6;
  localparam int HITS_PER_PHASE = 272;
  localparam int HOLD_CYCLES    = 250;   // long receiver hold-off

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  // trigger_number[31:0], hit_x, hit_y, brightness[31:0]
  logic [IN_W-1:0]        s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  // out_trigger[31:0], corrected_x[15:0], corrected_y[15:0], out_brightness[31:0]
  logic [OUT_TDATA_W-1:0] m_tdata;
  // charge[2:0], matched
  logic [OUT_TUSER_W-1:0] m_tuser;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [APB_ADDR_W-1:0]  paddr;
  logic [APB_DATA_W-1:0]  pwdata;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  int failures;
  int pending;
  int matched_seen;

  // circle settings as last written, used to aim hits at the circles
  int cfg_x [NUM_CIRCLES];
  int cfg_y [NUM_CIRCLES];
  int cfg_r [NUM_CIRCLES];

  int hits_sent;
  int settings_used;
  bit gaps_on;      // random idling on both streams
  bit hold_req;     // asks the receiver for one long hold-off
  bit hold_taken;   // receiver has started that hold-off
  int hold_left;    // hold-off cycles left, counted down by the receiver
  int stall_left;
  int quiet;

  hit_charge_classify_undeflect_unit #(
    .COORD_BITS(CB)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  hccu_classify_checker #(
    .COORD_BITS(CB)
  ) hit_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .failures    (failures),
    .pending     (pending),
    .matched_seen(matched_seen)
  );

  always #5 clk = ~clk;

  // result side: long hold-off when asked, else random stall bursts
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog: ends the run once nothing has moved for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("FAIL hit_charge_classify_undeflect_unit");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic int clamp_coord(int v);
    if (v < 0) return 0;
    if (v > CMAX) return CMAX;
    return v;
  endfunction

  // one hit request, optionally after a random gap; returns after acceptance
  task automatic send_hit(logic [31:0] trig, int x, int y, logic [31:0] bright);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_W'({bright, y[CB-1:0], x[CB-1:0], trig});
    do @(posedge clk); while (!s_tready);
    hits_sent++;
  endtask

  // setup cycle then access cycle
  task automatic apb_write(logic [2:0] idx, logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // junk above the packed fields must be dropped by the block
  task automatic set_circle(logic [2:0] idx, int x, int y, int r);
    logic [APB_DATA_W-1:0] d;
    cfg_x[idx] = x;
    cfg_y[idx] = y;
    cfg_r[idx] = r;
    d = {$urandom, $urandom};
    d[3*CB-1:0] = {x[CB-1:0], y[CB-1:0], r[CB-1:0]};
    apb_write(idx, d);
  endtask

  // drain everything in flight, then let the pipeline idle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  // mostly small circles, now and then a huge one; plus a write to an
  // unused register slot that must change nothing
  task automatic random_circles();
    for (int k = 0; k < NUM_CIRCLES; k++)
      set_circle(hccu_reg_t'(k), $urandom_range(0, CMAX), $urandom_range(0, CMAX),
                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, CMAX)
                                             : $urandom_range(0, 400));
    apb_write(3'($urandom_range(NUM_CIRCLES, 7)), {$urandom, $urandom});
    settings_used++;
  endtask

  // most hits are aimed around a circle so every charge shows up
  task automatic random_hit();
    int k, x, y;
    if ($urandom_range(0, 99) < 65) begin
      k = $urandom_range(0, NUM_CIRCLES - 1);
      x = clamp_coord(cfg_x[k] + int'($urandom_range(0, 2*cfg_r[k])) - cfg_r[k]);
      y = clamp_coord(cfg_y[k] + int'($urandom_range(0, 2*cfg_r[k])) - cfg_r[k]);
    end else begin
      x = $urandom_range(0, CMAX);
      y = $urandom_range(0, CMAX);
    end
    send_hit($urandom, x, y, $urandom);
  endtask

  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    gaps_on       = 1'b1;
    hold_req      = 1'b0;
    hits_sent     = 0;
    settings_used = 1;
    for (int k = 0; k < NUM_CIRCLES; k++) begin
      cfg_x[k] = 0;
      cfg_y[k] = 0;
      cfg_r[k] = 0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // circles at reset: all zero, so only the origin lands in circle zero
    send_hit(32'h0, 0, 0, 32'hFFFF_FFFF);
    send_hit(32'hFFFF_FFFF, 0, 1, 32'h0);
    send_hit($urandom, CMAX, CMAX, $urandom);
    wait_idle();

    // hand-picked circles: circle one and two overlap, circle four is a point;
    // deflection is +200 in x and -100 in y
    set_circle(REG_CIRCLE_ZERO, 2000, 2000, 100);
    set_circle(REG_CIRCLE_ONE, 1000, 1000, 300);
    set_circle(REG_CIRCLE_TWO, 1200, 900, 300);
    set_circle(REG_CIRCLE_THREE, 3000, 500, 50);
    set_circle(REG_CIRCLE_FOUR, 500, 3500, 0);
    apb_write(3'(NUM_CIRCLES), '1);  // past the last circle, ignored
    settings_used++;
    send_hit(32'h0, 2000, 2000, 32'h0);                 // center of charge zero
    send_hit(32'hFFFF_FFFF, 2060, 2080, 32'hFFFF_FFFF); // right on the rim
    send_hit($urandom, 2061, 2080, $urandom);           // just outside
    send_hit($urandom, 1000, 1000, $urandom);           // overlap, charge one wins
    send_hit($urandom, 1100, 950, $urandom);            // overlap again
    send_hit($urandom, 1450, 900, $urandom);            // charge two only
    send_hit($urandom, 3000, 500, $urandom);            // charge three
    send_hit($urandom, 3030, 540, $urandom);            // charge three rim
    send_hit($urandom, 500, 3500, $urandom);            // charge four, x goes negative
    send_hit($urandom, 501, 3500, $urandom);            // misses the point circle
    send_hit(32'hFFFF_FFFF, 0, 0, 32'h0);               // corners, no match
    send_hit(32'h0, CMAX, CMAX, 32'hFFFF_FFFF);
    send_hit($urandom, CMAX, 0, $urandom);
    send_hit($urandom, 0, CMAX, $urandom);
    wait_idle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      // last stretch runs at full rate; the circle writes below outlast any
      // stall burst still running
      if (p == RAND_PHASES - 1)
        gaps_on = 1'b0;
      case (p)
        1: begin
          // huge circles at opposite corners, all-ones fields in circle three
          set_circle(REG_CIRCLE_ZERO, 0, 0, 0);
          set_circle(REG_CIRCLE_ONE, 0, 0, CMAX);
          set_circle(REG_CIRCLE_TWO, CMAX, CMAX, CMAX);
          set_circle(REG_CIRCLE_THREE, CMAX, CMAX, CMAX);
          set_circle(REG_CIRCLE_FOUR, $urandom_range(0, CMAX), $urandom_range(0, CMAX), 200);
          settings_used++;
        end
        2: begin
          // largest negative deflection, charge four covers the whole plane
          set_circle(REG_CIRCLE_ZERO, $urandom_range(0, CMAX), $urandom_range(0, CMAX), 0);
          set_circle(REG_CIRCLE_ONE, CMAX, CMAX, 0);
          set_circle(REG_CIRCLE_TWO, 0, 0, 0);
          set_circle(REG_CIRCLE_THREE, $urandom_range(0, CMAX), $urandom_range(0, CMAX), 0);
          set_circle(REG_CIRCLE_FOUR, 2048, 2048, CMAX);
          settings_used++;
        end
        3: begin
          // largest positive deflection
          set_circle(REG_CIRCLE_ZERO, $urandom_range(0, CMAX), $urandom_range(0, CMAX), 0);
          set_circle(REG_CIRCLE_ONE, 0, 0, 0);
          set_circle(REG_CIRCLE_TWO, CMAX, CMAX, 0);
          set_circle(REG_CIRCLE_THREE, $urandom_range(0, CMAX), $urandom_range(0, CMAX), 30);
          set_circle(REG_CIRCLE_FOUR, 2048, 2048, CMAX);
          settings_used++;
        end
        default: random_circles();
      endcase
      // fill the block up against a stalled result side
      if (p == 4)
        hold_req = 1'b1;
      repeat (HITS_PER_PHASE) random_hit();
      wait_idle();
    end

    $display("ran %0d hits over %0d circle settings, %0d of them inside a circle",
             hits_sent, settings_used, matched_seen);
    $display("settings covered reset, overlap, point and corner circles, extreme deflection");
    if (failures == 0 && pending == 0) begin
      $display("PASS hit_charge_classify_undeflect_unit");
    end else begin
      $display("FAIL hit_charge_classify_undeflect_unit");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/hccu_pkg.sv
sv/hccu_circle_lane.sv
sv/hit_charge_classify_undeflect_unit.sv
verif/hccu_classify_checker.sv
verif/hit_charge_classify_undeflect_unit_test.sv
